/* sv/pbch_resource_element_extractor_assert.svh */
// assertion macros for the pbch resource element extractor
// used by the top level only; needs nothing else
`ifndef PBCH_RESOURCE_ELEMENT_EXTRACTOR_ASSERT_SVH
`define PBCH_RESOURCE_ELEMENT_EXTRACTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PREE_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("pbch extractor assertion failed");

// next-cycle implication, checked outside reset
`define PREE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("pbch extractor assertion failed");

`endif

/* sv/pree_pkg.sv */
// shared types, constants and helper functions for the pbch extractor
// no dependencies
package pree_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int NUM_PARTS      = 6;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CARRIER_BITS   = 11;
    localparam int SYMBOL_BITS    = 8;
    localparam int INDEX_BITS     = 8;

    localparam logic [6:0]  PBCH_WIDTH       = 7'd72;
    localparam logic [7:0]  FRAME_SYMBOLS    = 8'd140;
    localparam logic [7:0]  REF_SYMBOL_OUT   = 8'd48;
    localparam logic [7:0]  FULL_SYMBOL_BASE = 8'd96;
    localparam logic [7:0]  BLOCK_LEN        = 8'd240;
    localparam logic [7:0]  FIRST_SYMBOL     = 8'd7;
    localparam logic [6:0]  NRB_MIN          = 7'd6;
    localparam logic [6:0]  NRB_MAX          = 7'd110;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CELL_ID       = 2'd0,
        REG_CELL_ID_VALID = 2'd1,
        REG_N_RB_DL       = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                    cell_valid;
        logic [1:0]              cell_mod3;
        logic [CARRIER_BITS-1:0] pbch_start;
        logic [CARRIER_BITS-1:0] last_carrier;
    } cfg_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  last;
    } res_ctl_t;

    // floor(x / 3) by reciprocal multiply, exact for all 8-bit x
    function automatic logic [7:0] div3(input logic [7:0] x);
        logic [15:0] p;
        p = {8'd0, x} * 16'd171;
        return {1'b0, p[15:9]};
    endfunction

    // 9-bit value mod 3: bit weights alternate 1 and 2
    function automatic logic [1:0] mod3_9(input logic [8:0] v);
        logic [7:0] s;
        logic [7:0] r;
        s = 8'(v[0]) + 8'(v[2]) + 8'(v[4]) + 8'(v[6]) + 8'(v[8])
          + 8'({v[1], 1'b0}) + 8'({v[3], 1'b0}) + 8'({v[5], 1'b0}) + 8'({v[7], 1'b0});
        r = s - 8'(8'd3 * div3(s));
        return r[1:0];
    endfunction

endpackage

/* sv/pree_cfg.sv */
// configuration registers with derived symbol geometry
// depends on pree_pkg
module pree_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pree_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pree_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output pree_pkg::cfg_t                        cfg
);

    logic                                cell_valid_reg;
    logic [1:0]                          cell_mod3_reg;
    logic [pree_pkg::CARRIER_BITS-1:0]   pbch_start_reg;
    logic [pree_pkg::CARRIER_BITS-1:0]   last_carrier_reg;
    logic [6:0]                          nrb;
    logic [pree_pkg::CARRIER_BITS-1:0]   carrier_total;

    // clamp resource blocks, then 12*nrb subcarriers, window starts at 6*nrb - 36
    always_comb
    begin
        nrb = cfg_data[6:0];
        if (nrb < pree_pkg::NRB_MIN)
        begin
            nrb = pree_pkg::NRB_MIN;
        end
        else if (nrb > pree_pkg::NRB_MAX)
        begin
            nrb = pree_pkg::NRB_MAX;
        end
        carrier_total = 11'(11'd12 * {4'd0, nrb});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg   <= 1'b0;
            cell_mod3_reg    <= 2'd0;
            pbch_start_reg   <= '0;
            last_carrier_reg <= 11'd71;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pree_pkg::REG_CELL_ID:
                begin
                    cell_mod3_reg <= pree_pkg::mod3_9(cfg_data);
                end
                pree_pkg::REG_CELL_ID_VALID:
                begin
                    cell_valid_reg <= cfg_data[0];
                end
                pree_pkg::REG_N_RB_DL:
                begin
                    pbch_start_reg   <= {1'b0, carrier_total[10:1]} - 11'(pree_pkg::PBCH_WIDTH / 2);
                    last_carrier_reg <= carrier_total - 11'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.cell_valid   = cell_valid_reg;
    assign cfg.cell_mod3    = cell_mod3_reg;
    assign cfg.pbch_start   = pbch_start_reg;
    assign cfg.last_carrier = last_carrier_reg;

endmodule

/* sv/pree_extract.sv */
// input register, subcarrier and symbol counters, and extraction decision
// depends on pree_pkg
module pree_extract #(
    parameter int SAMPLE_BITS = pree_pkg::SAMPLE_BITS
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  pree_pkg::cfg_t                                      cfg,
    input  logic                                                in_valid,
    output logic                                                in_ready,
    input  logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]     in_samples,
    input  logic                                                tag_valid,
    input  logic [pree_pkg::SYMBOL_BITS-1:0]                    tag_symbol,
    input  logic                                                out_space,
    output logic                                                res_load,
    output pree_pkg::res_ctl_t                                  res_ctl,
    output logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]     res_samples
);

    logic                                               in_valid_reg;
    logic                                               in_valid_next;
    logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]    samples_reg;
    logic                                               tag_valid_reg;
    logic [pree_pkg::SYMBOL_BITS-1:0]                   tag_symbol_reg;
    logic [pree_pkg::CARRIER_BITS-1:0]                  carrier_reg;
    logic [pree_pkg::CARRIER_BITS-1:0]                  carrier_next;
    logic [pree_pkg::SYMBOL_BITS-1:0]                   symbol_reg;
    logic [pree_pkg::SYMBOL_BITS-1:0]                   symbol_next;

    logic                                               accept;
    logic                                               item_go;
    logic                                               hit;
    logic [pree_pkg::SYMBOL_BITS-1:0]                   sym_eff;
    logic [pree_pkg::CARRIER_BITS-1:0]                  offs;
    logic [7:0]                                         c;
    logic [7:0]                                         c_mod3;
    logic [7:0]                                         q;
    logic [7:0]                                         base;
    logic [7:0]                                         idx;
    logic                                               in_win;

    always_comb
    begin
        // resync only on the first subcarrier and with an in-range symbol
        if (tag_valid_reg && (carrier_reg == '0) && (tag_symbol_reg < pree_pkg::FRAME_SYMBOLS))
        begin
            sym_eff = tag_symbol_reg;
        end
        else
        begin
            sym_eff = symbol_reg;
        end

        offs   = carrier_reg - cfg.pbch_start;
        c      = {1'b0, offs[6:0]};
        in_win = (sym_eff >= pree_pkg::FIRST_SYMBOL) && (sym_eff <= pree_pkg::FIRST_SYMBOL + 8'd3)
              && (carrier_reg >= cfg.pbch_start) && (offs < 11'(pree_pkg::PBCH_WIDTH));
        c_mod3 = c - 8'(8'd3 * pree_pkg::div3(c));
        q      = pree_pkg::div3(c + 8'd2 - {6'd0, cfg.cell_mod3});

        hit  = 1'b0;
        base = '0;
        idx  = '0;
        if (in_win)
        begin
            if (sym_eff < pree_pkg::FIRST_SYMBOL + 8'd2)
            begin
                // reference symbols skip every third subcarrier
                base = (sym_eff == pree_pkg::FIRST_SYMBOL) ? 8'd0 : pree_pkg::REF_SYMBOL_OUT;
                hit  = (c_mod3[1:0] != cfg.cell_mod3);
                idx  = base + c - q;
            end
            else
            begin
                base = (sym_eff == pree_pkg::FIRST_SYMBOL + 8'd2) ? pree_pkg::FULL_SYMBOL_BASE
                     : pree_pkg::FULL_SYMBOL_BASE + 8'(pree_pkg::PBCH_WIDTH);
                hit  = 1'b1;
                idx  = base + c;
            end
        end
        hit = hit && cfg.cell_valid;

        if (carrier_reg >= cfg.last_carrier)
        begin
            carrier_next = '0;
            symbol_next  = (sym_eff >= pree_pkg::FRAME_SYMBOLS - 8'd1) ? 8'd0 : sym_eff + 8'd1;
        end
        else
        begin
            carrier_next = carrier_reg + 11'd1;
            symbol_next  = sym_eff;
        end

        item_go  = in_valid_reg && (!hit || out_space);
        in_ready = !in_valid_reg || item_go;
        accept   = in_valid && in_ready;

        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (item_go)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            carrier_reg  <= '0;
            symbol_reg   <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            // counters hold while the cell identity is unknown
            if (item_go && cfg.cell_valid)
            begin
                carrier_reg <= carrier_next;
                symbol_reg  <= symbol_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samples_reg    <= in_samples;
            tag_valid_reg  <= tag_valid;
            tag_symbol_reg <= tag_symbol;
        end
    end

    assign res_load      = item_go && hit;
    assign res_ctl.index = idx;
    assign res_ctl.last  = (idx == pree_pkg::BLOCK_LEN - 8'd1);
    assign res_samples   = samples_reg;

endmodule

/* sv/pree_out.sv */
// result register holding one extracted sample until it is taken
// depends on pree_pkg
module pree_out #(
    parameter int SAMPLE_BITS = pree_pkg::SAMPLE_BITS
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                res_load,
    input  pree_pkg::res_ctl_t                                  res_ctl,
    input  logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]     res_samples,
    output logic                                                out_space,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output pree_pkg::res_ctl_t                                  out_ctl,
    output logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]     out_samples
);

    logic                                               out_valid_reg;
    logic                                               out_valid_next;
    pree_pkg::res_ctl_t                                 ctl_reg;
    logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]    samples_reg;

    always_comb
    begin
        out_space = !out_valid_reg || out_ready;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            ctl_reg     <= res_ctl;
            samples_reg <= res_samples;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_ctl     = ctl_reg;
    assign out_samples = samples_reg;

endmodule

/* sv/pbch_resource_element_extractor.sv */
// PBCH resource element extractor, top level: one subcarrier transaction in per clock, three
// antenna streams side by side; the 240 broadcast-channel samples of each frame come out with
// their index and a last flag on index 239. An item is accepted every cycle while results are
// taken; a result passes the input register, then the result register, with the single
// decision stage between them that classifies the subcarrier and steps the subcarrier and
// symbol counters. While cell_id_valid is 0, input is accepted and dropped.
// Depends on pree_pkg, pree_cfg, pree_extract, pree_out and the assertion macro header.
`include "pbch_resource_element_extractor_assert.svh"

module pbch_resource_element_extractor #(
    parameter int SAMPLE_BITS = pree_pkg::SAMPLE_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [pree_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [pree_pkg::CFG_DATA_BITS-1:0]          cfg_data,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic signed [SAMPLE_BITS-1:0]               a_re,
    input  logic signed [SAMPLE_BITS-1:0]               a_im,
    input  logic signed [SAMPLE_BITS-1:0]               b_re,
    input  logic signed [SAMPLE_BITS-1:0]               b_im,
    input  logic signed [SAMPLE_BITS-1:0]               c_re,
    input  logic signed [SAMPLE_BITS-1:0]               c_im,
    input  logic                                        tag_valid,
    input  logic [pree_pkg::SYMBOL_BITS-1:0]            tag_symbol,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic signed [SAMPLE_BITS-1:0]               out_a_re,
    output logic signed [SAMPLE_BITS-1:0]               out_a_im,
    output logic signed [SAMPLE_BITS-1:0]               out_b_re,
    output logic signed [SAMPLE_BITS-1:0]               out_b_im,
    output logic signed [SAMPLE_BITS-1:0]               out_c_re,
    output logic signed [SAMPLE_BITS-1:0]               out_c_im,
    output logic [pree_pkg::INDEX_BITS-1:0]             out_index,
    output logic                                        last
);

    pree_pkg::cfg_t                                     cfg;
    logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]    in_samples;
    logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]    res_samples;
    logic [pree_pkg::NUM_PARTS-1:0][SAMPLE_BITS-1:0]    out_samples;
    pree_pkg::res_ctl_t                                 res_ctl;
    pree_pkg::res_ctl_t                                 out_ctl;
    logic                                               res_load;
    logic                                               out_space;

    assign in_samples[0] = a_re;
    assign in_samples[1] = a_im;
    assign in_samples[2] = b_re;
    assign in_samples[3] = b_im;
    assign in_samples[4] = c_re;
    assign in_samples[5] = c_im;

    pree_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pree_extract #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_extract (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_samples  (in_samples),
        .tag_valid   (tag_valid),
        .tag_symbol  (tag_symbol),
        .out_space   (out_space),
        .res_load    (res_load),
        .res_ctl     (res_ctl),
        .res_samples (res_samples)
    );

    pree_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_load    (res_load),
        .res_ctl     (res_ctl),
        .res_samples (res_samples),
        .out_space   (out_space),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_ctl     (out_ctl),
        .out_samples (out_samples)
    );

    assign out_a_re  = out_samples[0];
    assign out_a_im  = out_samples[1];
    assign out_b_re  = out_samples[2];
    assign out_b_im  = out_samples[3];
    assign out_c_re  = out_samples[4];
    assign out_c_im  = out_samples[5];
    assign out_index = out_ctl.index;
    assign last      = out_ctl.last;

    // last marks exactly the final index of the block
    `PREE_ASSERT_NOW(a_last_index, clk, rst_n, out_valid, last == (out_index == pree_pkg::BLOCK_LEN - 8'd1))
    // index stays inside the broadcast block
    `PREE_ASSERT_NOW(a_index_range, clk, rst_n, out_valid, out_index < pree_pkg::BLOCK_LEN)
    // an empty result register never stalls the input side
    `PREE_ASSERT_NOW(a_no_false_stall, clk, rst_n, !out_valid, in_ready)
    // no result appears while the cell identity is unknown
    `PREE_ASSERT_NEXT(a_quiet_when_invalid, clk, rst_n, !cfg.cell_valid && !out_valid, !out_valid)

endmodule

/* dv/pree_result_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the pbch resource element extractor: follows register writes, predicts the
// extracted samples from input transactions and checks every output transaction against them
// depends on pree_pkg
module pree_result_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [pree_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [pree_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] a_re,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] a_im,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] b_re,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] b_im,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] c_re,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] c_im,
    input  logic                                    tag_valid,
    input  logic [pree_pkg::SYMBOL_BITS-1:0]        tag_symbol,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] out_a_re,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] out_a_im,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] out_b_re,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] out_b_im,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] out_c_re,
    input  logic signed [pree_pkg::SAMPLE_BITS-1:0] out_c_im,
    input  logic [pree_pkg::INDEX_BITS-1:0]         out_index,
    input  logic                                    last,
    output int                                      fail_count,
    output int                                      pending_results
);

    typedef struct packed {
        logic signed [pree_pkg::SAMPLE_BITS-1:0] a_re;
        logic signed [pree_pkg::SAMPLE_BITS-1:0] a_im;
        logic signed [pree_pkg::SAMPLE_BITS-1:0] b_re;
        logic signed [pree_pkg::SAMPLE_BITS-1:0] b_im;
        logic signed [pree_pkg::SAMPLE_BITS-1:0] c_re;
        logic signed [pree_pkg::SAMPLE_BITS-1:0] c_im;
        logic [pree_pkg::INDEX_BITS-1:0]         index;
        logic                                    last;
    } pbch_sample_t;

    pbch_sample_t extracted_q[$];

    logic [pree_pkg::CFG_DATA_BITS-1:0] cell_id_cfg;
    logic                               cell_on_cfg;
    logic [6:0]                         nrb_cfg;
    logic [pree_pkg::CARRIER_BITS-1:0]  carrier_q;
    logic [pree_pkg::SYMBOL_BITS-1:0]   symbol_q;

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic take_result();
        pbch_sample_t want;
        if (extracted_q.size() == 0)
        begin
            $error("output transaction with no expected sample, out_index %0d", out_index);
            fail_count++;
        end
        else
        begin
            want = extracted_q.pop_front();
            check_field("out_a_re", $signed(want.a_re), $signed(out_a_re));
            check_field("out_a_im", $signed(want.a_im), $signed(out_a_im));
            check_field("out_b_re", $signed(want.b_re), $signed(out_b_re));
            check_field("out_b_im", $signed(want.b_im), $signed(out_b_im));
            check_field("out_c_re", $signed(want.c_re), $signed(out_c_re));
            check_field("out_c_im", $signed(want.c_im), $signed(out_c_im));
            check_field("out_index", int'(want.index), int'(out_index));
            check_field("last", int'(want.last), int'(last));
        end
    endtask

    // classify one subcarrier, queue its sample if it belongs to the broadcast block,
    // then step the subcarrier and symbol counters
    task automatic demap_subcarrier();
        int nrb, n_car, pbch_lo, width, first_sym, m, car, sym, c, idx;
        logic hit;
        pbch_sample_t s;
        nrb = int'(nrb_cfg);
        if (nrb < int'(pree_pkg::NRB_MIN)) nrb = int'(pree_pkg::NRB_MIN);
        if (nrb > int'(pree_pkg::NRB_MAX)) nrb = int'(pree_pkg::NRB_MAX);
        width = int'(pree_pkg::PBCH_WIDTH);
        first_sym = int'(pree_pkg::FIRST_SYMBOL);
        n_car = 12 * nrb;
        pbch_lo = n_car / 2 - width / 2;
        m = int'(cell_id_cfg) % 3;

        // resync only on the first subcarrier of a symbol and only for a legal symbol
        if (tag_valid && carrier_q == 0 && tag_symbol < pree_pkg::FRAME_SYMBOLS)
            symbol_q = tag_symbol;

        car = int'(carrier_q);
        sym = int'(symbol_q);
        hit = 1'b0;
        idx = 0;
        if (sym >= first_sym && sym <= first_sym + 3 && car >= pbch_lo && car < pbch_lo + width)
        begin
            c = car - pbch_lo;
            if (sym < first_sym + 2)
            begin
                // reference symbols drop every offset congruent to the cell id
                if (c % 3 != m)
                begin
                    hit = 1'b1;
                    idx = int'(pree_pkg::REF_SYMBOL_OUT) * (sym - first_sym) + c - (c + 2 - m) / 3;
                end
            end
            else
            begin
                hit = 1'b1;
                idx = int'(pree_pkg::FULL_SYMBOL_BASE) + width * (sym - first_sym - 2) + c;
            end
        end

        if (hit)
        begin
            s.a_re = a_re;
            s.a_im = a_im;
            s.b_re = b_re;
            s.b_im = b_im;
            s.c_re = c_re;
            s.c_im = c_im;
            s.index = idx[pree_pkg::INDEX_BITS-1:0];
            s.last = (idx == int'(pree_pkg::BLOCK_LEN) - 1);
            extracted_q.push_back(s);
        end

        if (car + 1 >= n_car)
        begin
            carrier_q = '0;
            symbol_q = (sym + 1 >= int'(pree_pkg::FRAME_SYMBOLS)) ? '0 : symbol_q + 1'b1;
        end
        else
        begin
            carrier_q = carrier_q + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_id_cfg = '0;
            cell_on_cfg = 1'b0;
            nrb_cfg = pree_pkg::NRB_MIN;
            carrier_q = '0;
            symbol_q = '0;
            extracted_q.delete();
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                take_result();
            if (in_valid && in_ready && cell_on_cfg)
                demap_subcarrier();
            if (cfg_we)
            begin
                case (pree_pkg::cfg_reg_t'(cfg_index))
                    pree_pkg::REG_CELL_ID:       cell_id_cfg = cfg_data;
                    pree_pkg::REG_CELL_ID_VALID: cell_on_cfg = cfg_data[0];
                    pree_pkg::REG_N_RB_DL:       nrb_cfg = cfg_data[6:0];
                    default: ;
                endcase
            end
            pending_results = extracted_q.size();
        end
    end

endmodule

/* dv/pbch_resource_element_extractor_tb.sv */
`timescale 1ns / 1ps
// testbench top for the pbch resource element extractor: clock, reset, register writes,
// subcarrier stimulus and output backpressure; prediction and checking sit in pree_result_checker
// depends on pree_pkg, pree_result_checker and the extractor rtl
module pbch_resource_element_extractor_tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int ITEM_COUNT    = 600;
    localparam int SETTLE_CYCLES = 8;

    logic                                    clk = 1'b0;
    logic                                    rst_n;
    logic                                    cfg_we;
    pree_pkg::cfg_reg_t                      cfg_index;
    logic [pree_pkg::CFG_DATA_BITS-1:0]      cfg_data;
    logic                                    in_valid;
    logic                                    in_ready;
    logic signed [pree_pkg::SAMPLE_BITS-1:0] a_re, a_im, b_re, b_im, c_re, c_im;
    logic                                    tag_valid;
    logic [pree_pkg::SYMBOL_BITS-1:0]        tag_symbol;
    logic                                    out_valid;
    logic                                    out_ready = 1'b0;
    logic signed [pree_pkg::SAMPLE_BITS-1:0] out_a_re, out_a_im, out_b_re, out_b_im;
    logic signed [pree_pkg::SAMPLE_BITS-1:0] out_c_re, out_c_im;
    logic [pree_pkg::INDEX_BITS-1:0]         out_index;
    logic                                    last;
    int                                      fail_count;
    int                                      pending_results;

    // stimulus-side view of where the subcarrier counter stands
    int   car_pos = 0;
    int   n_car = 72;
    logic cell_on = 1'b0;
    int   counted = 0;
    int   extreme_left = 0;
    bit   no_idle = 1'b0;
    int   cycle_count = 0;
    int unsigned ready_hold = 0;

    pbch_resource_element_extractor dut (.*);

    pree_result_checker checker_i (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output backpressure: long ready stretches, mostly short stalls, a few long ones
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if ($urandom_range(0, 2) != 0)
        begin
            out_ready <= 1'b1;
            ready_hold <= $urandom_range(0, 50);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end
    end

    function automatic logic [pree_pkg::SAMPLE_BITS-1:0] next_sample();
        logic [pree_pkg::SAMPLE_BITS-1:0] corner [4];
        corner[0] = {1'b0, {(pree_pkg::SAMPLE_BITS-1){1'b1}}};
        corner[1] = {1'b1, {(pree_pkg::SAMPLE_BITS-1){1'b0}}};
        corner[2] = '0;
        corner[3] = '1;
        if (extreme_left > 0)
        begin
            extreme_left--;
            return corner[extreme_left % 4];
        end
        if ($urandom_range(0, 99) < 12)
            return corner[$urandom_range(0, 3)];
        return pree_pkg::SAMPLE_BITS'($urandom());
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(input pree_pkg::cfg_reg_t r,
                             input logic [pree_pkg::CFG_DATA_BITS-1:0] v);
        int nrb;
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        nrb = int'(v[6:0]);
        if (nrb < int'(pree_pkg::NRB_MIN)) nrb = int'(pree_pkg::NRB_MIN);
        if (nrb > int'(pree_pkg::NRB_MAX)) nrb = int'(pree_pkg::NRB_MAX);
        if (r == pree_pkg::REG_N_RB_DL) n_car = 12 * nrb;
        if (r == pree_pkg::REG_CELL_ID_VALID) cell_on = v[0];
    endtask

    // drain: no input, every expected sample out, then a settling wait for the pipeline
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_item(input logic tv, input logic [pree_pkg::SYMBOL_BITS-1:0] ts);
        int gap;
        in_valid <= 1'b1;
        a_re <= next_sample();
        a_im <= next_sample();
        b_re <= next_sample();
        b_im <= next_sample();
        c_re <= next_sample();
        c_im <= next_sample();
        tag_valid <= tv;
        tag_symbol <= ts;
        do @(posedge clk); while (!in_ready);
        counted++;
        if (cell_on)
            car_pos = (car_pos + 1 >= n_car) ? 0 : car_pos + 1;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stray tags in the middle of a symbol should be ignored
    task automatic feed_carriers(input int count, input logic tag_first,
                                 input logic [pree_pkg::SYMBOL_BITS-1:0] tsym);
        for (int k = 0; k < count; k++)
        begin
            if (k == 0 && tag_first)
                push_item(1'b1, tsym);
            else if ($urandom_range(0, 49) == 0)
                push_item(1'b1, pree_pkg::SYMBOL_BITS'($urandom_range(0, 255)));
            else
                push_item(1'b0, pree_pkg::SYMBOL_BITS'($urandom()));
        end
    endtask

    // runs to the end of the current symbol; a counter past the end wraps on one transaction
    task automatic feed_symbol(input logic tag_first,
                               input logic [pree_pkg::SYMBOL_BITS-1:0] tsym);
        feed_carriers((car_pos >= n_car - 1) ? 1 : n_car - car_pos, tag_first, tsym);
    endtask

    initial
    begin
        int unsigned sel;
        int nsym;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = pree_pkg::REG_CELL_ID;
        cfg_data = '0;
        in_valid = 1'b0;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        c_re = '0;
        c_im = '0;
        tag_valid = 1'b0;
        tag_symbol = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cell identity unknown: transactions are dropped
        feed_carriers(3, 1'b1, 8'd7);
        settle();
        write_reg(pree_pkg::REG_CELL_ID, 9'd0);
        write_reg(pree_pkg::REG_N_RB_DL, 9'd0);
        write_reg(pree_pkg::REG_CELL_ID_VALID, 9'd1);

        // one whole broadcast block from a tag on symbol 7, corner sample values up front
        extreme_left = 48;
        feed_symbol(1'b1, 8'd7);
        repeat (3) feed_symbol(1'b0, 8'd0);
        // last symbol of the frame, counter wraps to symbol 0
        feed_symbol(1'b1, 8'd139);

        // wider symbol, window of symbol 9, left part way through
        settle();
        no_idle = 1'b1;
        write_reg(pree_pkg::REG_N_RB_DL, 9'd16);
        feed_carriers(100, 1'b1, 8'd9);
        settle();
        no_idle = 1'b0;
        // counter now sits past the end of a 72-subcarrier symbol
        write_reg(pree_pkg::REG_N_RB_DL, 9'd6);
        feed_symbol(1'b0, 8'd0);
        settle();
        write_reg(pree_pkg::REG_CELL_ID, 9'd503);
        feed_carriers(10, 1'b1, 8'd7);
        push_item(1'b1, 8'd9);
        feed_symbol(1'b0, 8'd0);

        while (counted < ITEM_COUNT)
        begin
            settle();
            sel = $urandom_range(0, 9);
            write_reg(pree_pkg::REG_CELL_ID, (sel < 2) ? 9'($urandom_range(500, 511))
                                                       : 9'($urandom_range(0, 511)));
            sel = $urandom_range(0, 9);
            write_reg(pree_pkg::REG_N_RB_DL, (sel < 6) ? 9'd6 :
                                             (sel < 8) ? 9'($urandom_range(0, 5))
                                                       : 9'($urandom_range(7, 16)));
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(pree_pkg::REG_CELL_ID_VALID, 9'd0);
                feed_carriers($urandom_range(1, 6), 1'b1, 8'($urandom_range(0, 255)));
                settle();
                write_reg(pree_pkg::REG_CELL_ID_VALID, 9'd1);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            if (car_pos != 0)
                feed_symbol(1'b0, 8'd0);
            if ($urandom_range(0, 3) == 0)
            begin
                feed_symbol(1'b1, 8'd7);
                repeat (3) feed_symbol(1'b0, 8'd0);
            end
            else
            begin
                nsym = $urandom_range(1, 2);
                repeat (nsym)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 8)
                        feed_symbol(1'b1, 8'($urandom_range(6, 11)));
                    else
                        feed_symbol(sel == 8, 8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 2) == 0)
                feed_carriers($urandom_range(1, 80), 1'b0, 8'd0);
        end

        settle();
        if (fail_count == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/pree_pkg.sv
sv/pree_cfg.sv
sv/pree_extract.sv
sv/pree_out.sv
sv/pbch_resource_element_extractor.sv
dv/pree_result_checker.sv
dv/pbch_resource_element_extractor_tb.sv
